[rtl/sc2gp_pkg.sv]
// Shared types and constants for the scan code to gamepad event translator.
// Used by sc2gp_decode and scancode_to_gamepad_events; depends on nothing.
package sc2gp_pkg;

	typedef enum logic [1:0] {
		KIND_KEY  = 2'd0,
		KIND_ABS  = 2'd1,
		KIND_SYNC = 2'd2
	} event_kind_t;

	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [6:0] CODE_MASK   = 7'h7f;

	localparam logic [6:0] KEY_A       = 7'd30;
	localparam logic [6:0] KEY_B       = 7'd48;
	localparam logic [6:0] KEY_X       = 7'd45;
	localparam logic [6:0] KEY_Y       = 7'd21;
	localparam logic [6:0] KEY_L       = 7'd38;
	localparam logic [6:0] KEY_R       = 7'd19;
	localparam logic [6:0] KEY_T       = 7'd20;
	localparam logic [6:0] KEY_S       = 7'd31;
	localparam logic [6:0] ARROW_UP    = 7'd103;
	localparam logic [6:0] ARROW_DOWN  = 7'd108;
	localparam logic [6:0] ARROW_LEFT  = 7'd105;
	localparam logic [6:0] ARROW_RIGHT = 7'd106;

	localparam logic [3:0] DIR_UP    = 4'b0001;
	localparam logic [3:0] DIR_DOWN  = 4'b0010;
	localparam logic [3:0] DIR_LEFT  = 4'b0100;
	localparam logic [3:0] DIR_RIGHT = 4'b1000;

	localparam logic [2:0] AXIS_X     = 3'd0;
	localparam logic [2:0] AXIS_Y     = 3'd1;
	localparam logic [2:0] AXIS_HAT_X = 3'd2;
	localparam logic [2:0] AXIS_HAT_Y = 3'd3;
	localparam logic [2:0] SYNC_CODE  = 3'd0;

	localparam logic signed [15:0] AXIS_FULL = 16'sd32767;
	localparam logic signed [15:0] AXIS_LOW  = -16'sd32767;

	localparam logic [2:0] KEY_LAST_BEAT = 3'd1;
	localparam logic [2:0] HAT_LAST_BEAT = 3'd4;

	typedef struct packed {
		logic [7:0]        buttons;
		logic [3:0]        dirs;
		logic signed [1:0] hat_h;
		logic signed [1:0] hat_v;
	} pad_state_t;

	typedef struct packed {
		logic              emit;
		logic              is_hat;
		logic [2:0]        btn;
		logic              pressed;
		logic signed [1:0] hat_x;
		logic signed [1:0] hat_y;
	} report_t;

endpackage

[rtl/sc2gp_decode.sv]
// Decodes one scan byte against the current pad state into the next state
// and a report descriptor. Depends on sc2gp_pkg.
module sc2gp_decode import sc2gp_pkg::*; (
	input  logic [7:0] scan_byte,
	input  pad_state_t cur,
	output pad_state_t nxt,
	output report_t    rpt
);

	logic              pressed;
	logic [6:0]        key;
	logic [3:0]        dir;
	logic [3:0]        new_dirs;
	logic              btn_hit;
	logic [2:0]        btn;
	logic [7:0]        btn_bit;
	logic signed [1:0] nx;
	logic signed [1:0] ny;

	function automatic logic signed [1:0] resolve(input logic n, input logic p);
		if (n && !p) begin
			return -2'sd1;
		end else if (p && !n) begin
			return 2'sd1;
		end
		return 2'sd0;
	endfunction

	assign pressed = (scan_byte & RELEASE_BIT) == 8'h00;
	assign key     = scan_byte[6:0] & CODE_MASK;

	always_comb begin
		dir = 4'b0000;
		unique case (key)
			ARROW_UP:    dir = DIR_UP;
			ARROW_DOWN:  dir = DIR_DOWN;
			ARROW_LEFT:  dir = DIR_LEFT;
			ARROW_RIGHT: dir = DIR_RIGHT;
			default:     dir = 4'b0000;
		endcase
	end

	always_comb begin
		btn_hit = 1'b1;
		btn     = 3'd0;
		unique case (key)
			KEY_A:   btn = 3'd0;
			KEY_B:   btn = 3'd1;
			KEY_X:   btn = 3'd2;
			KEY_Y:   btn = 3'd3;
			KEY_L:   btn = 3'd4;
			KEY_R:   btn = 3'd5;
			KEY_T:   btn = 3'd6;
			KEY_S:   btn = 3'd7;
			default: btn_hit = 1'b0;
		endcase
	end

	assign btn_bit  = 8'b1 << btn;
	assign new_dirs = pressed ? (cur.dirs | dir) : (cur.dirs & ~dir);
	assign nx       = resolve(new_dirs[2], new_dirs[3]);
	assign ny       = resolve(new_dirs[0], new_dirs[1]);

	always_comb begin
		nxt         = cur;
		rpt         = '0;
		rpt.btn     = btn;
		rpt.pressed = pressed;
		rpt.hat_x   = nx;
		rpt.hat_y   = ny;
		if (dir != 4'b0000) begin
			nxt.dirs = new_dirs;
			if (nx != cur.hat_h || ny != cur.hat_v) begin
				nxt.hat_h  = nx;
				nxt.hat_v  = ny;
				rpt.emit   = 1'b1;
				rpt.is_hat = 1'b1;
			end
		end else if (btn_hit && ((|(cur.buttons & btn_bit)) != pressed)) begin
			nxt.buttons = pressed ? (cur.buttons | btn_bit) : (cur.buttons & ~btn_bit);
			rpt.emit    = 1'b1;
		end
	end

endmodule

[rtl/scancode_to_gamepad_events.sv]
// Scan code to gamepad event translator, top level.
// Reset clears all flags, the hat and the pipeline. An item's first event is offered once
// it moves from byte_s1 into rpt_q, which waits while a report is being sent. Throughput:
// one item per cycle for bytes that emit nothing while no report is pending; a button or
// hat change holds the next item until its events and sync are taken, one per ready cycle.
// Depends on sc2gp_pkg and sc2gp_decode.
module scancode_to_gamepad_events import sc2gp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] event_kind, [4:2] event_code, [20:5] event_value
	output logic        m_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	pad_state_t state_q;
	pad_state_t state_nxt;
	report_t    dec_rpt;
	report_t    rpt_q;
	logic       rpt_valid_q;
	logic [2:0] beat_q;
	logic       last_beat;
	logic       rpt_done;
	logic       advance;

	event_kind_t       ev_kind;
	logic [2:0]        ev_code;
	logic signed [15:0] ev_value;

	function automatic logic signed [15:0] scale(input logic signed [1:0] h);
		if (h == -2'sd1) begin
			return AXIS_LOW;
		end else if (h == 2'sd1) begin
			return AXIS_FULL;
		end
		return 16'sd0;
	endfunction

	sc2gp_decode u_decode (
		.scan_byte(byte_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.rpt      (dec_rpt)
	);

	assign last_beat = rpt_q.is_hat ? (beat_q == HAT_LAST_BEAT) : (beat_q == KEY_LAST_BEAT);
	assign rpt_done  = rpt_valid_q && m_tready && last_beat;
	assign advance   = valid_s1 && (!rpt_valid_q || rpt_done);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			rpt_valid_q <= 1'b0;
			beat_q      <= 3'd0;
			rpt_q       <= '0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				rpt_valid_q <= dec_rpt.emit;
				rpt_q       <= dec_rpt;
				beat_q      <= 3'd0;
			end else if (rpt_done) begin
				rpt_valid_q <= 1'b0;
			end else if (rpt_valid_q && m_tready) begin
				beat_q <= beat_q + 3'd1;
			end
		end
	end

	always_comb begin
		ev_kind  = KIND_SYNC;
		ev_code  = SYNC_CODE;
		ev_value = 16'sd0;
		if (!last_beat) begin
			if (rpt_q.is_hat) begin
				ev_kind = KIND_ABS;
				unique case (beat_q)
					3'd0: begin
						ev_code  = AXIS_X;
						ev_value = scale(rpt_q.hat_x);
					end
					3'd1: begin
						ev_code  = AXIS_Y;
						ev_value = scale(rpt_q.hat_y);
					end
					3'd2: begin
						ev_code  = AXIS_HAT_X;
						ev_value = {{14{rpt_q.hat_x[1]}}, rpt_q.hat_x};
					end
					default: begin
						ev_code  = AXIS_HAT_Y;
						ev_value = {{14{rpt_q.hat_y[1]}}, rpt_q.hat_y};
					end
				endcase
			end else begin
				ev_kind  = KIND_KEY;
				ev_code  = rpt_q.btn;
				ev_value = {15'd0, rpt_q.pressed};
			end
		end
	end

	assign m_tvalid = rpt_valid_q;
	assign m_tdata  = {3'b000, ev_value, ev_code, ev_kind};
	assign m_tlast  = last_beat;

endmodule

[test/scancode_to_gamepad_events_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for scancode_to_gamepad_events: scan bytes go in on the input stream
// and every output event is checked against directed rows or an in-bench model of the pad state.
// Depends on sc2gp_pkg and the RTL of the translator.
module scancode_to_gamepad_events_tb import sc2gp_pkg::*; ();

	localparam int RANDOM_SCANS  = 405;
	localparam int STEADY_TAIL   = 60;
	localparam int PRESSURE_HOLD = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 10;

	localparam logic [2:0] BTN_A = 3'd0;
	localparam logic [2:0] BTN_B = 3'd1;
	localparam logic [2:0] BTN_X = 3'd2;
	localparam logic [2:0] BTN_Y = 3'd3;
	localparam logic [2:0] BTN_L = 3'd4;
	localparam logic [2:0] BTN_R = 3'd5;
	localparam logic [2:0] BTN_T = 3'd6;
	localparam logic [2:0] BTN_S = 3'd7;

	localparam logic [7:0][6:0] BUTTON_KEYS =
		{KEY_S, KEY_T, KEY_R, KEY_L, KEY_Y, KEY_X, KEY_B, KEY_A};
	localparam logic [3:0][6:0] ARROW_KEYS = {ARROW_RIGHT, ARROW_LEFT, ARROW_DOWN, ARROW_UP};

	typedef struct packed {
		event_kind_t       kind;
		logic [2:0]        code;
		logic signed [15:0] value;
		logic              last;
	} pad_event_t;

	typedef enum logic [1:0] {
		ROW_CALC,
		ROW_QUIET,
		ROW_KEY
	} row_kind_t;

	typedef struct packed {
		logic [7:0] scan;
		row_kind_t  kind;
		logic [2:0] code;
	} scan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	pad_event_t pending_events[$];
	scan_row_t  directed_rows[$];
	pad_event_t want;

	logic [7:0]        held_buttons = 8'h00;
	logic [3:0]        held_dirs = 4'h0;
	logic signed [1:0] hat_h = 2'sd0;
	logic signed [1:0] hat_v = 2'sd0;

	int  errors = 0;
	int  scans_accepted = 0;
	int  events_checked = 0;
	int  button_changes = 0;
	int  hat_moves = 0;
	int  quiet_scans = 0;
	int  idle_cycles = 0;
	bit  steady_tail = 1'b0;
	bit  pressure_done = 1'b0;

	scancode_to_gamepad_events uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [1:0] resolve_axis(input logic neg, input logic pos);
		if (neg && !pos)
			return -2'sd1;
		if (pos && !neg)
			return 2'sd1;
		return 2'sd0;
	endfunction

	function automatic logic signed [15:0] stick_value(input logic signed [1:0] hat);
		if (hat > 0)
			return AXIS_FULL;
		if (hat < 0)
			return AXIS_LOW;
		return 16'sd0;
	endfunction

	function automatic void push_event(input event_kind_t kind, input logic [2:0] code,
			input logic signed [15:0] value, input logic last);
		pad_event_t ev;
		ev.kind = kind;
		ev.code = code;
		ev.value = value;
		ev.last = last;
		pending_events.push_back(ev);
	endfunction

	function automatic void add_row(input logic [7:0] scan, input row_kind_t kind,
			input logic [2:0] code);
		scan_row_t row;
		row.scan = scan;
		row.kind = kind;
		row.code = code;
		directed_rows.push_back(row);
	endfunction

	// Updates the pad state for one scan byte and, if asked, queues the events it causes.
	function automatic void advance_pad(input logic [7:0] scan, input bit record);
		logic              pressed;
		logic [6:0]        key;
		logic [3:0]        dir;
		logic signed [1:0] nx;
		logic signed [1:0] ny;
		bit                found;
		logic [2:0]        btn;
		pressed = (scan & RELEASE_BIT) == 8'h00;
		key = scan[6:0] & CODE_MASK;
		dir = 4'h0;
		found = 1'b0;
		btn = BTN_A;
		case (key)
			ARROW_UP: dir = DIR_UP;
			ARROW_DOWN: dir = DIR_DOWN;
			ARROW_LEFT: dir = DIR_LEFT;
			ARROW_RIGHT: dir = DIR_RIGHT;
			default: dir = 4'h0;
		endcase
		for (int i = 0; i < 8; i++) begin
			if (key == BUTTON_KEYS[i]) begin
				found = 1'b1;
				btn = i[2:0];
			end
		end
		if (dir != 4'h0) begin
			held_dirs = pressed ? (held_dirs | dir) : (held_dirs & ~dir);
			nx = resolve_axis(|(held_dirs & DIR_LEFT), |(held_dirs & DIR_RIGHT));
			ny = resolve_axis(|(held_dirs & DIR_UP), |(held_dirs & DIR_DOWN));
			if (nx != hat_h || ny != hat_v) begin
				hat_h = nx;
				hat_v = ny;
				hat_moves++;
				if (record) begin
					push_event(KIND_ABS, AXIS_X, stick_value(nx), 1'b0);
					push_event(KIND_ABS, AXIS_Y, stick_value(ny), 1'b0);
					push_event(KIND_ABS, AXIS_HAT_X, {{14{nx[1]}}, nx}, 1'b0);
					push_event(KIND_ABS, AXIS_HAT_Y, {{14{ny[1]}}, ny}, 1'b0);
					push_event(KIND_SYNC, SYNC_CODE, 16'sd0, 1'b1);
				end
			end else begin
				quiet_scans++;
			end
		end else if (found && held_buttons[btn] != pressed) begin
			held_buttons[btn] = pressed;
			button_changes++;
			if (record) begin
				push_event(KIND_KEY, btn, {15'd0, pressed}, 1'b0);
				push_event(KIND_SYNC, SYNC_CODE, 16'sd0, 1'b1);
			end
		end else begin
			quiet_scans++;
		end
	endfunction

	task automatic send_scan(input logic [7:0] scan, input bit may_idle);
		int gap;
		gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= scan;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scans_accepted++;
	endtask

	initial begin : stimulus
		logic [7:0] scan;
		int         pick;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(8'h00, ROW_QUIET, BTN_A);
		add_row(8'h7f, ROW_QUIET, BTN_A);
		add_row(8'h80, ROW_QUIET, BTN_A);
		add_row(8'hff, ROW_QUIET, BTN_A);
		add_row({1'b0, KEY_A}, ROW_KEY, BTN_A);
		add_row({1'b0, KEY_A}, ROW_QUIET, BTN_A);
		add_row({1'b1, KEY_A}, ROW_KEY, BTN_A);
		add_row({1'b1, KEY_A}, ROW_QUIET, BTN_A);
		add_row({1'b0, KEY_B}, ROW_KEY, BTN_B);
		add_row({1'b0, KEY_X}, ROW_KEY, BTN_X);
		add_row({1'b0, KEY_Y}, ROW_KEY, BTN_Y);
		add_row({1'b0, KEY_L}, ROW_KEY, BTN_L);
		add_row({1'b0, KEY_R}, ROW_KEY, BTN_R);
		add_row({1'b0, KEY_T}, ROW_KEY, BTN_T);
		add_row({1'b0, KEY_S}, ROW_KEY, BTN_S);
		add_row({1'b0, ARROW_UP}, ROW_CALC, BTN_A);
		add_row({1'b0, ARROW_DOWN}, ROW_CALC, BTN_A);
		add_row({1'b0, ARROW_DOWN}, ROW_QUIET, BTN_A);
		add_row({1'b1, ARROW_UP}, ROW_CALC, BTN_A);
		add_row({1'b0, ARROW_LEFT}, ROW_CALC, BTN_A);
		add_row({1'b0, ARROW_RIGHT}, ROW_CALC, BTN_A);
		add_row({1'b1, ARROW_LEFT}, ROW_CALC, BTN_A);
		add_row({1'b1, KEY_S}, ROW_KEY, BTN_S);
		add_row({1'b1, ARROW_RIGHT}, ROW_CALC, BTN_A);
		add_row({1'b1, ARROW_DOWN}, ROW_CALC, BTN_A);

		foreach (directed_rows[i]) begin
			send_scan(directed_rows[i].scan, 1'b1);
			advance_pad(directed_rows[i].scan, directed_rows[i].kind == ROW_CALC);
			if (directed_rows[i].kind == ROW_KEY) begin
				push_event(KIND_KEY, directed_rows[i].code,
					{15'd0, ~directed_rows[i].scan[7]}, 1'b0);
				push_event(KIND_SYNC, SYNC_CODE, 16'sd0, 1'b1);
			end
		end

		// Mostly mapped keys with a random press or release, the rest any byte at all.
		for (int i = 0; i < RANDOM_SCANS; i++) begin
			if (i == RANDOM_SCANS - STEADY_TAIL)
				steady_tail = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 2)
				scan = 8'($urandom_range(0, 255));
			else if (pick < 5)
				scan = {$urandom_range(0, 1) == 1, ARROW_KEYS[2'($urandom_range(0, 3))]};
			else
				scan = {$urandom_range(0, 1) == 1, BUTTON_KEYS[3'($urandom_range(0, 7))]};
			send_scan(scan, !steady_tail);
			advance_pad(scan, 1'b1);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d scan bytes: %0d button changes, %0d hat moves, %0d quiet bytes.",
			scans_accepted, button_changes, hat_moves, quiet_scans);
		$display("Checked %0d events, including a long output stall that backed up the input.",
			events_checked);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// The output side stalls in bursts, once for a long stretch, and never in the tail.
	initial begin : event_sink
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = 0;
			if (!steady_tail && !pressure_done && scans_accepted >= 60) begin
				stall = PRESSURE_HOLD;
				pressure_done = 1'b1;
			end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 16);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("event with none expected: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				if (m_tdata[1:0] !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[4:2] !== want.code) begin
					$error("event_code: expected %0d, got %0d", want.code, m_tdata[4:2]);
					errors++;
				end
				if (m_tdata[20:5] !== want.value) begin
					$error("event_value: expected %0d, got %0d", want.value,
						$signed(m_tdata[20:5]));
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_report: expected %b, got %b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d events outstanding.",
				IDLE_LIMIT, pending_events.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/sc2gp_pkg.sv
rtl/sc2gp_decode.sv
rtl/scancode_to_gamepad_events.sv
test/scancode_to_gamepad_events_tb.sv
